### src/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the lru key/value cache
// Entry width, store depth, cell control group and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

	localparam int NumEntries = 16;
	localparam int KeyBits    = 32;
	localparam int ValueBits  = 32;
	localparam int CapBits    = 5;
	localparam int CountBits  = $clog2(NumEntries + 1);
	localparam int DataBits   = 32;
	localparam int AddrBits   = 3;

	localparam logic [CapBits-1:0] CapReset = CapBits'(16);

	// register indexes
	localparam logic RegCapacity = 1'b0;

	// operation codes
	localparam logic CmdGet = 1'b0;
	localparam logic CmdPut = 1'b1;

	typedef struct packed {
		logic                 valid;
		logic [KeyBits-1:0]   key;
		logic [ValueBits-1:0] value;
	} entry_t;

	typedef struct packed {
		logic lookup;
		logic shift;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPDATE
	} state_t;

endpackage

`default_nettype wire

### src/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell: one slot of the recency-ordered entry chain
// Holds one entry, compares it against the probe key and takes its
// neighbor's entry when the chain shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire lkv_pkg::cell_ctl_t     ctl,
	input  wire [lkv_pkg::KeyBits-1:0]  probe_key,
	input  wire lkv_pkg::entry_t        prev,
	output lkv_pkg::entry_t             cur,
	output logic                        match
);
	import lkv_pkg::*;

	logic                 valid_q;
	logic [KeyBits-1:0]   key_q;
	logic [ValueBits-1:0] value_q;
	logic                 match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.shift) begin
				valid_q <= prev.valid;
			end
			if (ctl.lookup) begin
				match_q <= valid_q && (key_q == probe_key);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

	assign cur.valid = valid_q;
	assign cur.key   = key_q;
	assign cur.value = value_q;
	assign match     = match_q;

endmodule

`default_nettype wire

### src/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value store, lru replacement
// Chain of cells kept in recency order, most recent entry in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser is the command (0 get, 1 put), tdata
//   holds the key in bits 31:0 and the put value in bits 63:32.
//   m_axis returns one response per request: tdata is the read value (stored
//   value on a get hit, all ones on a get miss, zero for a put), tuser bit 0
//   is hit, bit 1 is evicted.
//   The apb port holds capacity_limit at address 0 (0 acts as 1, values above
//   the store depth saturate); write it only while no request is in flight.
//   Each request passes through three steps: accept, a lookup step where every cell
//   compares its key against the probe, and an update step where the chain
//   shifts the hit or new entry to the front and the response is registered.
//   A new request is accepted only in idle, once the previous one has left the
//   update step; a stalled response holds the update step, so at most one
//   response waits in the output register while the next request is taken.
//   Reset empties the store and sets capacity_limit to 16; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache (
	input  wire                                clk,
	input  wire                                arst_n,
	// apb configuration
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [lkv_pkg::AddrBits-1:0]       paddr,
	input  wire  [lkv_pkg::DataBits-1:0]       pwdata,
	output logic [lkv_pkg::DataBits-1:0]       prdata,
	output logic                               pready,
	// request stream
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire  [63:0]                        s_axis_tdata,  // key, write_value
	input  wire                                s_axis_tuser,  // command
	// response stream
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	output logic [31:0]                        m_axis_tdata,  // read_value
	output logic [1:0]                         m_axis_tuser   // hit, evicted
);
	import lkv_pkg::*;

	state_t state_q, state_d;

	logic [CapBits-1:0]   cap_q;
	logic [CountBits-1:0] count_q;

	logic                 cmd_q;
	logic [KeyBits-1:0]   key_q;
	logic [ValueBits-1:0] wval_q;

	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic [1:0]  out_user_q;

	entry_t    chain [NumEntries+1];
	cell_ctl_t ctl   [NumEntries];
	logic [NumEntries-1:0] match_vec;
	logic [NumEntries-1:0] valid_vec;

	logic                 accept;
	logic                 do_update;
	logic                 any_hit;
	logic                 full;
	logic [ValueBits-1:0] hit_value;
	entry_t               head;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
		end else if (psel && penable && pwrite && pready && paddr[2] == RegCapacity
				&& paddr[1:0] == 2'b00) begin
			cap_q <= pwdata[CapBits-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == RegCapacity) begin
			prdata[CapBits-1:0] = cap_q;
		end
	end

	// sequencer
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign do_update     = (state_q == ST_UPDATE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (do_update) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_axis_tuser;
			key_q  <= s_axis_tdata[KeyBits-1:0];
			wval_q <= s_axis_tdata[63:32];
		end
	end

	// hit value and occupancy
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < NumEntries; i++) begin
			hit_value = hit_value | ({ValueBits{match_vec[i]}} & chain[i+1].value);
		end
	end

	assign any_hit = |match_vec;

	always_comb begin
		int eff;
		eff = int'(cap_q);
		if (eff < 1) begin
			eff = 1;
		end
		if (eff > NumEntries) begin
			eff = NumEntries;
		end
		full = int'(count_q) >= eff;
	end

	always_comb begin
		head.valid = 1'b1;
		head.key   = key_q;
		head.value = (cmd_q == CmdPut) ? wval_q : hit_value;
	end

	// shift enables: a hit moves cells up to the hit slot, an insert moves
	// the occupied run (plus one free slot when not full)
	always_comb begin
		int last;
		last = full ? int'(count_q) - 1 : int'(count_q);
		for (int i = 0; i < NumEntries; i++) begin
			ctl[i].lookup = (state_q == ST_LOOK);
			if (!do_update) begin
				ctl[i].shift = 1'b0;
			end else if (any_hit) begin
				ctl[i].shift = |(match_vec >> i);
			end else begin
				ctl[i].shift = (cmd_q == CmdPut) && (i <= last);
			end
		end
	end

	assign chain[0] = head;

	for (genvar g = 0; g < NumEntries; g++) begin : g_cell
		lkv_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[g]),
			.probe_key (key_q),
			.prev      (chain[g]),
			.cur       (chain[g+1]),
			.match     (match_vec[g])
		);
		assign valid_vec[g] = chain[g+1].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_update && !any_hit && cmd_q == CmdPut && !full) begin
			count_q <= count_q + 1'b1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_update) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_update) begin
			if (cmd_q == CmdPut) begin
				out_data_q <= '0;
			end else if (any_hit) begin
				out_data_q <= hit_value;
			end else begin
				out_data_q <= '1;
			end
			out_user_q <= {(cmd_q == CmdPut) && !any_hit && full, any_hit};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= NumEntries)
		else $error("occupancy above store depth");

	a_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("occupancy does not match valid cells");

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("valid cells not packed at the front of the chain");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |-> $onehot0(match_vec))
		else $error("key present in more than one cell");

	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_LOOK)
		else $error("request accepted without lookup");

endmodule

`default_nettype wire
